[src/cdc_pkg.sv]
// Shared types, constants, microcode program and calendar helpers for the date counter.
`default_nettype none

package cdc_pkg;

    // Field widths
    localparam int COUNT_WIDTH = 16;
    localparam int YEAR_WIDTH  = 12;
    localparam int DAY_WIDTH   = 5;
    localparam int MONTH_WIDTH = 4;
    localparam int MOD100_WIDTH = 7;

    // Calendar constants
    localparam logic [YEAR_WIDTH-1:0]  YEAR_MAX     = YEAR_WIDTH'((2 ** YEAR_WIDTH) - 1);
    localparam logic [YEAR_WIDTH-1:0]  YEAR_SET_MIN = YEAR_WIDTH'(1900);
    localparam logic [YEAR_WIDTH-1:0]  YEAR_SET_MAX = YEAR_WIDTH'(2100);
    localparam logic [YEAR_WIDTH-1:0]  YEAR_CENTURY = YEAR_WIDTH'(100);
    localparam logic [MOD100_WIDTH-1:0] MOD100_LAST = MOD100_WIDTH'(99);
    localparam logic [MONTH_WIDTH-1:0] MONTH_JAN    = MONTH_WIDTH'(1);
    localparam logic [MONTH_WIDTH-1:0] MONTH_FEB    = MONTH_WIDTH'(2);
    localparam logic [MONTH_WIDTH-1:0] MONTH_DEC    = MONTH_WIDTH'(12);
    localparam logic [DAY_WIDTH-1:0]   DAY_FIRST    = DAY_WIDTH'(1);
    localparam logic [DAY_WIDTH-1:0]   DAY_LAST_DEC = DAY_WIDTH'(31);

    // Century index (mod 4) of years 1900, 2000 and 2100
    localparam logic [1:0] CENT_1900 = 2'd3;
    localparam logic [1:0] CENT_2000 = 2'd0;
    localparam logic [1:0] CENT_2100 = 2'd1;

    // Item kinds
    localparam logic KIND_SET     = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Command transaction payload
    typedef struct packed {
        logic                   kind;
        logic [DAY_WIDTH-1:0]   set_day;
        logic [MONTH_WIDTH-1:0] set_month;
        logic [YEAR_WIDTH-1:0]  set_year;
        logic [COUNT_WIDTH-1:0] day_count;
    } cmd_t;

    // Date transaction payload
    typedef struct packed {
        logic [DAY_WIDTH-1:0]   cur_day;
        logic [MONTH_WIDTH-1:0] cur_month;
        logic [YEAR_WIDTH-1:0]  cur_year;
        logic                   bad_date;
        logic                   year_overflow;
    } date_t;

    // Datapath operations driven by the control word
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET,
        OP_STEP,
        OP_EMIT
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_CMD_IDLE,
        COND_KIND_ADV,
        COND_COUNT_NZ,
        COND_OUT_BUSY
    } cond_t;

    // Program step addresses
    typedef logic [2:0] step_t;
    localparam step_t STEP_WAIT     = 3'd0;
    localparam step_t STEP_DISPATCH = 3'd1;
    localparam step_t STEP_SET      = 3'd2;
    localparam step_t STEP_ADVANCE  = 3'd3;
    localparam step_t STEP_EMIT     = 3'd4;

    // One control word: operation, condition, target when taken, target otherwise
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump;
        step_t next;
    } ucode_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic cmd_valid;
        logic kind_adv;
        logic count_nz;
        logic out_busy;
    } status_t;

    // Control store
    function automatic ucode_t ucode_at(input step_t step);
        ucode_t word;
        case (step)
            STEP_WAIT:     word = '{OP_LOAD, COND_CMD_IDLE, STEP_WAIT,     STEP_DISPATCH};
            STEP_DISPATCH: word = '{OP_NONE, COND_KIND_ADV, STEP_ADVANCE,  STEP_SET};
            STEP_SET:      word = '{OP_SET,  COND_ALWAYS,   STEP_EMIT,     STEP_EMIT};
            STEP_ADVANCE:  word = '{OP_STEP, COND_COUNT_NZ, STEP_ADVANCE,  STEP_EMIT};
            STEP_EMIT:     word = '{OP_EMIT, COND_OUT_BUSY, STEP_EMIT,     STEP_WAIT};
            default:       word = '{OP_NONE, COND_ALWAYS,   STEP_WAIT,     STEP_WAIT};
        endcase
        return word;
    endfunction

    // Length of a month, February stretched in leap years
    function automatic logic [DAY_WIDTH-1:0] month_len(input logic [MONTH_WIDTH-1:0] m,
                                                       input logic leap);
        logic [DAY_WIDTH-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_WIDTH'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_WIDTH'(30);
            4'd2:    len = leap ? DAY_WIDTH'(29) : DAY_WIDTH'(28);
            default: len = DAY_WIDTH'(0);
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[src/cdc_sequencer.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module cdc_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cdc_pkg::status_t status,
    output cdc_pkg::op_t          op
);

    cdc_pkg::step_t  step_reg;
    cdc_pkg::step_t  step_next;
    cdc_pkg::ucode_t word;
    logic            take;

    // Fetch the control word and resolve the jump
    always_comb
    begin
        word = cdc_pkg::ucode_at(step_reg);
        case (word.cond)
            cdc_pkg::COND_ALWAYS:   take = 1'b1;
            cdc_pkg::COND_CMD_IDLE: take = !status.cmd_valid;
            cdc_pkg::COND_KIND_ADV: take = status.kind_adv;
            cdc_pkg::COND_COUNT_NZ: take = status.count_nz;
            cdc_pkg::COND_OUT_BUSY: take = status.out_busy;
            default:                take = 1'b1;
        endcase
        step_next = take ? word.jump : word.next;
        op        = word.op;
    end

    // Hold the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= cdc_pkg::STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

[src/calendar_date_counter_unit.sv]
// Top level of the calendar date counter: handshake, date datapath and output register.
//
//   channel | dir | payload          | handshake
//   cmd     | in  | cdc_pkg::cmd_t   | cmd_valid / cmd_ready
//   date    | out | cdc_pkg::date_t  | date_valid / date_ready
//
// A set transaction passes the dispatch, set and emit steps before the next acceptance; an
// advance by N days stays in the advance step until the count is spent, since the shared
// day step unit moves the date by one day per cycle under the microcode program.
// Reset loads January 1, 1900 and empties the output register.
// A new command is taken while the previous date still waits in the output register;
// the result of that command then holds in the program until the register frees.
`default_nettype none

module calendar_date_counter_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire cdc_pkg::cmd_t  cmd,
    output logic                date_valid,
    input  wire logic           date_ready,
    output cdc_pkg::date_t      date
);

    cdc_pkg::op_t     op;
    cdc_pkg::status_t status;

    cdc_pkg::cmd_t    cmd_reg, cmd_next;
    logic [cdc_pkg::COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [cdc_pkg::DAY_WIDTH-1:0]    day_reg, day_next;
    logic [cdc_pkg::MONTH_WIDTH-1:0]  month_reg, month_next;
    logic [cdc_pkg::YEAR_WIDTH-1:0]   year_reg, year_next;
    logic [cdc_pkg::MOD100_WIDTH-1:0] mod100_reg, mod100_next;
    logic [1:0]                       cent_reg, cent_next;
    logic                             bad_reg, bad_next;
    logic                             ovf_reg, ovf_next;
    cdc_pkg::date_t                   out_reg, out_next;
    logic                             out_valid_reg, out_valid_next;

    logic                             set_leap;
    logic                             set_ok;
    logic [cdc_pkg::YEAR_WIDTH-1:0]   set_off;
    logic                             cur_leap;
    logic [cdc_pkg::DAY_WIDTH-1:0]    cur_len;

    cdc_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    // Report datapath status to the sequencer
    always_comb
    begin
        status.cmd_valid = cmd_valid;
        status.kind_adv  = (cmd_reg.kind == cdc_pkg::KIND_ADVANCE);
        status.count_nz  = (count_reg != '0);
        status.out_busy  = out_valid_reg && !date_ready;
    end

    // Check the stored set request
    always_comb
    begin
        set_leap = (cmd_reg.set_year[1:0] == 2'b00) &&
                   (cmd_reg.set_year != cdc_pkg::YEAR_SET_MIN) &&
                   (cmd_reg.set_year != cdc_pkg::YEAR_SET_MAX);
        set_ok   = (cmd_reg.set_month >= cdc_pkg::MONTH_JAN) &&
                   (cmd_reg.set_month <= cdc_pkg::MONTH_DEC) &&
                   (cmd_reg.set_year >= cdc_pkg::YEAR_SET_MIN) &&
                   (cmd_reg.set_year <= cdc_pkg::YEAR_SET_MAX) &&
                   (cmd_reg.set_day != '0) &&
                   (cmd_reg.set_day <= cdc_pkg::month_len(cmd_reg.set_month, set_leap));
        set_off  = cmd_reg.set_year - cdc_pkg::YEAR_SET_MIN;
    end

    // Derive leap year and month length of the current date
    always_comb
    begin
        cur_leap = (mod100_reg == '0) ? (cent_reg == cdc_pkg::CENT_2000)
                                      : (year_reg[1:0] == 2'b00);
        cur_len  = cdc_pkg::month_len(month_reg, cur_leap);
    end

    // Execute the operation of the current control word
    always_comb
    begin
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        mod100_next = mod100_reg;
        cent_next   = cent_reg;
        bad_next    = bad_reg;
        ovf_next    = ovf_reg;
        out_next    = out_reg;
        out_valid_next = out_valid_reg && !date_ready;
        cmd_ready   = 1'b0;

        case (op)
            cdc_pkg::OP_LOAD:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    count_next = cmd.day_count;
                    bad_next   = 1'b0;
                    ovf_next   = 1'b0;
                end
            end
            cdc_pkg::OP_SET:
            begin
                if (set_ok)
                begin
                    day_next   = cmd_reg.set_day;
                    month_next = cmd_reg.set_month;
                    year_next  = cmd_reg.set_year;
                    // split the year into century index and year within century
                    if (set_off < cdc_pkg::YEAR_CENTURY)
                    begin
                        mod100_next = cdc_pkg::MOD100_WIDTH'(set_off);
                        cent_next   = cdc_pkg::CENT_1900;
                    end
                    else if (set_off < (cdc_pkg::YEAR_CENTURY << 1))
                    begin
                        mod100_next = cdc_pkg::MOD100_WIDTH'(set_off - cdc_pkg::YEAR_CENTURY);
                        cent_next   = cdc_pkg::CENT_2000;
                    end
                    else
                    begin
                        mod100_next = cdc_pkg::MOD100_WIDTH'(set_off -
                                                             (cdc_pkg::YEAR_CENTURY << 1));
                        cent_next   = cdc_pkg::CENT_2100;
                    end
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            cdc_pkg::OP_STEP:
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - cdc_pkg::COUNT_WIDTH'(1);
                    if (day_reg < cur_len)
                    begin
                        day_next = day_reg + cdc_pkg::DAY_WIDTH'(1);
                    end
                    else if (month_reg < cdc_pkg::MONTH_DEC)
                    begin
                        month_next = month_reg + cdc_pkg::MONTH_WIDTH'(1);
                        day_next   = cdc_pkg::DAY_FIRST;
                    end
                    else if (year_reg < cdc_pkg::YEAR_MAX)
                    begin
                        year_next  = year_reg + cdc_pkg::YEAR_WIDTH'(1);
                        month_next = cdc_pkg::MONTH_JAN;
                        day_next   = cdc_pkg::DAY_FIRST;
                        if (mod100_reg == cdc_pkg::MOD100_LAST)
                        begin
                            mod100_next = '0;
                            cent_next   = cent_reg + 2'd1;
                        end
                        else
                        begin
                            mod100_next = mod100_reg + cdc_pkg::MOD100_WIDTH'(1);
                        end
                    end
                    else
                    begin
                        // saturate at the last day and drop the remaining days
                        day_next   = cdc_pkg::DAY_LAST_DEC;
                        month_next = cdc_pkg::MONTH_DEC;
                        ovf_next   = 1'b1;
                        count_next = '0;
                    end
                end
            end
            cdc_pkg::OP_EMIT:
            begin
                if (!out_valid_reg || date_ready)
                begin
                    out_next.cur_day       = day_reg;
                    out_next.cur_month     = month_reg;
                    out_next.cur_year      = year_reg;
                    out_next.bad_date      = bad_reg;
                    out_next.year_overflow = ovf_reg;
                    out_valid_next         = 1'b1;
                end
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // Hold date state, day count, flags and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg       <= cdc_pkg::DAY_FIRST;
            month_reg     <= cdc_pkg::MONTH_JAN;
            year_reg      <= cdc_pkg::YEAR_SET_MIN;
            mod100_reg    <= '0;
            cent_reg      <= cdc_pkg::CENT_1900;
            count_reg     <= '0;
            bad_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            mod100_reg    <= mod100_next;
            cent_reg      <= cent_next;
            count_reg     <= count_next;
            bad_reg       <= bad_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign date_valid = out_valid_reg;
    assign date       = out_reg;

endmodule

`default_nettype wire

[src/cdc_checker.sv]
// Port-level checker for the calendar date counter and its bind to the top level.
`default_nettype none

module cdc_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           cmd_valid,
    input wire logic           cmd_ready,
    input wire logic           date_valid,
    input wire logic           date_ready,
    input wire cdc_pkg::date_t date
);

    // A stalled date transaction holds
    a_date_hold: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid && !date_ready |=> date_valid && $stable(date))
        else $error("date transaction changed while stalled");

    // After a command is taken, no second command is taken on the next edge
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while the previous one is in work");

    // A result never flags both a rejected set and a year overflow
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid |-> !(date.bad_date && date.year_overflow))
        else $error("both result flags raised");

    // Every reported date lies in a real month and day range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid |-> (date.cur_month >= cdc_pkg::MONTH_JAN) &&
                       (date.cur_month <= cdc_pkg::MONTH_DEC) &&
                       (date.cur_day >= cdc_pkg::DAY_FIRST) &&
                       (date.cur_day <= cdc_pkg::DAY_LAST_DEC))
        else $error("reported date out of range");

endmodule

bind calendar_date_counter_unit cdc_checker u_cdc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .date_valid (date_valid),
    .date_ready (date_ready),
    .date       (date)
);

`default_nettype wire

[tb/date_check_pkg.sv]
// Date tracker for the calendar date counter testbench: tracks the date and checks each result.
`default_nettype none

package date_check_pkg;

    import cdc_pkg::*;

    // Days in month m of year y; zero for a month outside 1..12
    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        bit leap;
        leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    class date_tracker;

        int unsigned day;
        int unsigned month;
        int unsigned year;
        date_t       dates_due[$];
        int unsigned mismatches;

        function new();
            day        = DAY_FIRST;
            month      = MONTH_JAN;
            year       = YEAR_SET_MIN;
            mismatches = 0;
        endfunction

        // Apply one accepted command transaction and queue the date it must report
        function void take_command(input cmd_t c);
            date_t       want;
            int unsigned left;
            bit          bad;
            bit          ovf;
            bad = 1'b0;
            ovf = 1'b0;
            if (c.kind == KIND_SET) begin
                // Load only a real date inside the settable year range
                if (c.set_month >= MONTH_JAN && c.set_month <= MONTH_DEC &&
                    c.set_year >= YEAR_SET_MIN && c.set_year <= YEAR_SET_MAX &&
                    c.set_day >= DAY_FIRST &&
                    c.set_day <= month_days(c.set_month, c.set_year)) begin
                    day   = c.set_day;
                    month = c.set_month;
                    year  = c.set_year;
                end else begin
                    bad = 1'b1;
                end
            end else begin
                // Step one day at a time; drop the rest once the last year is full
                left = c.day_count;
                while (left != 0) begin
                    left--;
                    if (day < month_days(month, year)) begin
                        day++;
                    end else if (month < MONTH_DEC) begin
                        month++;
                        day = DAY_FIRST;
                    end else if (year < YEAR_MAX) begin
                        year++;
                        month = MONTH_JAN;
                        day   = DAY_FIRST;
                    end else begin
                        ovf  = 1'b1;
                        left = 0;
                    end
                end
            end
            want.cur_day       = DAY_WIDTH'(day);
            want.cur_month     = MONTH_WIDTH'(month);
            want.cur_year      = YEAR_WIDTH'(year);
            want.bad_date      = bad;
            want.year_overflow = ovf;
            dates_due.push_back(want);
        endfunction

        // Compare one accepted date transaction with the oldest queued date
        function void check_date(input date_t got);
            date_t want;
            if (dates_due.size() == 0) begin
                $error("date transaction with no command outstanding: %p", got);
                mismatches++;
                return;
            end
            want = dates_due.pop_front();
            if (got.cur_day !== want.cur_day) begin
                $error("cur_day: expected %0d, actual %0d", want.cur_day, got.cur_day);
                mismatches++;
            end
            if (got.cur_month !== want.cur_month) begin
                $error("cur_month: expected %0d, actual %0d", want.cur_month, got.cur_month);
                mismatches++;
            end
            if (got.cur_year !== want.cur_year) begin
                $error("cur_year: expected %0d, actual %0d", want.cur_year, got.cur_year);
                mismatches++;
            end
            if (got.bad_date !== want.bad_date) begin
                $error("bad_date: expected %0b, actual %0b", want.bad_date, got.bad_date);
                mismatches++;
            end
            if (got.year_overflow !== want.year_overflow) begin
                $error("year_overflow: expected %0b, actual %0b",
                       want.year_overflow, got.year_overflow);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return dates_due.size();
        endfunction

    endclass

endpackage

`default_nettype wire

[tb/tb_top.sv]
// Top of the calendar date counter testbench: clock, reset, stimulus, receiver and checks.
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int unsigned RANDOM_ITEMS = 55;
    localparam int unsigned HOLD_AT      = 40;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned BIG_COUNT    = 3000;

    logic           clk        = 1'b0;
    logic           rst_n      = 1'b0;
    logic           cmd_valid  = 1'b0;
    logic           cmd_ready;
    cdc_pkg::cmd_t  cmd        = '0;
    logic           date_valid;
    logic           date_ready = 1'b0;
    cdc_pkg::date_t date;

    logic  hold_req   = 1'b0;
    logic  hold_taken = 1'b0;

    date_check_pkg::date_tracker tracker;

    always #5 clk = ~clk;

    calendar_date_counter_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .date_valid (date_valid),
        .date_ready (date_ready),
        .date       (date)
    );

    // Set command; the unused count field carries noise
    function automatic cdc_pkg::cmd_t set_item(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        cdc_pkg::cmd_t c;
        c.kind      = cdc_pkg::KIND_SET;
        c.set_day   = cdc_pkg::DAY_WIDTH'(d);
        c.set_month = cdc_pkg::MONTH_WIDTH'(m);
        c.set_year  = cdc_pkg::YEAR_WIDTH'(y);
        c.day_count = cdc_pkg::COUNT_WIDTH'($urandom);
        return c;
    endfunction

    // Advance command; the unused set fields carry noise
    function automatic cdc_pkg::cmd_t advance_item(input int unsigned n);
        cdc_pkg::cmd_t c;
        c.kind      = cdc_pkg::KIND_ADVANCE;
        c.set_day   = cdc_pkg::DAY_WIDTH'($urandom);
        c.set_month = cdc_pkg::MONTH_WIDTH'($urandom);
        c.set_year  = cdc_pkg::YEAR_WIDTH'($urandom);
        c.day_count = cdc_pkg::COUNT_WIDTH'(n);
        return c;
    endfunction

    // Mostly well-formed sets and short advances, the rest raw noise
    function automatic cdc_pkg::cmd_t random_cmd(input int unsigned max_count);
        cdc_pkg::cmd_t c;
        int unsigned   pick;
        int unsigned   m;
        int unsigned   y;
        int unsigned   len;
        int unsigned   span;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            m = $urandom_range(12, 1);
            case ($urandom_range(4))
                0:       y = cdc_pkg::YEAR_SET_MIN;
                1:       y = 2000;
                2:       y = cdc_pkg::YEAR_SET_MAX;
                3:       y = 4 * $urandom_range(525, 475);
                default: y = $urandom_range(cdc_pkg::YEAR_SET_MAX, cdc_pkg::YEAR_SET_MIN);
            endcase
            len = date_check_pkg::month_days(m, y);
            case ($urandom_range(7))
                0, 1:    c = set_item(len, m, y);
                2:       c = set_item(len + 1, m, y);
                3:       c = set_item(1, m, y);
                default: c = set_item($urandom_range(len, 1), m, y);
            endcase
        end
        else if (pick < 80)
        begin
            span = (max_count < 60) ? max_count : 60;
            if ($urandom_range(9) == 0)
                span = max_count;
            c = advance_item($urandom_range(span));
        end
        else
        begin
            c = set_item($urandom, $urandom, $urandom);
            c.kind = 1'($urandom_range(1));
            if (c.kind == cdc_pkg::KIND_ADVANCE)
                c.day_count = cdc_pkg::COUNT_WIDTH'($urandom_range(max_count));
        end
        return c;
    endfunction

    // Offer one command and hold it until the block takes it
    task automatic offer_command(input cdc_pkg::cmd_t c);
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(negedge clk);
        while (!cmd_ready)
            @(negedge clk);
        tracker.take_command(c);
        @(posedge clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        cmd_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop valid and wait until every queued date has come back
    task automatic drain_results();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    // Field extremes, every kind, leap rules and invalid sets
    task automatic run_directed();
        offer_command(advance_item(0));
        offer_command(advance_item(58));
        offer_command(advance_item(1));
        offer_command(set_item(29, 2, 1900));
        pause_sender(3);
        offer_command(set_item(29, 2, 2000));
        offer_command(set_item(29, 2, 2100));
        offer_command(set_item(0, 5, 2000));
        offer_command(set_item(31, 4, 2000));
        offer_command(set_item(1, 0, 2000));
        pause_sender(1);
        offer_command(set_item(1, 13, 2000));
        offer_command(set_item(31, 15, 4095));
        offer_command(set_item(1, 1, 1899));
        offer_command(set_item(1, 1, 2101));
        offer_command(set_item(0, 0, 0));
        offer_command(set_item(31, 12, 1999));
        offer_command(advance_item(1));
        pause_sender(2);
        offer_command(set_item(28, 2, 2024));
        offer_command(advance_item(1));
        offer_command(advance_item(1));
        offer_command(set_item(1, 1, 1900));
    endtask

    // Run from the last settable day up to the year limit and past it
    task automatic run_year_limit();
        offer_command(set_item(31, 12, 2100));
        repeat (12) offer_command(advance_item(65535));
        offer_command(advance_item(0));
        offer_command(advance_item(1));
    endtask

    // Random bursts, one long receiver hold and periodic drains
    task automatic run_random();
        int unsigned burst_left;
        burst_left = $urandom_range(12, 1);
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == HOLD_AT)
            begin
                hold_req = 1'b1;
                repeat (12) offer_command(random_cmd(4));
            end
            if (n % 35 == 34)
                drain_results();
            offer_command(random_cmd(BIG_COUNT));
            burst_left--;
            if (burst_left == 0)
            begin
                pause_sender($urandom_range(8, 1));
                burst_left = $urandom_range(12, 1);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_year_limit();
        drain_results();
        run_random();
        drain_results();
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("calendar_date_counter_unit regression: pass");
        else
            $display("calendar_date_counter_unit regression: fail");
        $finish;
    end

    // Receiver: stall in segments of random style, plus one long hold on request
    initial
    begin : receiver
        int unsigned span;
        int unsigned style;
        int unsigned tick;
        span = 0;
        style = 0;
        tick = 0;
        wait (rst_n == 1'b1);
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                date_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    span  = $urandom_range(60, 5);
                    style = $urandom_range(3);
                end
                span--;
                case (style)
                    0:       date_ready <= 1'b1;
                    1:       date_ready <= 1'($urandom_range(1));
                    2:       date_ready <= ($urandom_range(7) == 0);
                    default: date_ready <= (tick % 3 == 0);
                endcase
                tick++;
                @(posedge clk);
            end
        end
    end

    // Check each date transaction that the coming edge accepts
    always @(negedge clk)
    begin
        if (rst_n && date_valid && date_ready)
            tracker.check_date(date);
    end

    // Watchdog
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("calendar_date_counter_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
